// ===== src/steering_pid_with_deadband_top_defines.svh =====
// Assertion macros shared by the steering PID RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef STEERING_PID_WITH_DEADBAND_TOP_DEFINES_SVH
`define STEERING_PID_WITH_DEADBAND_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spid assertion failed");
`define SPID_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("spid forbidden condition seen");
`else
`define SPID_ASSERT(lbl, prop)
`define SPID_NEVER(lbl, cond)
`endif
`endif

// ===== src/spid_pkg.sv =====
// Package for the steering PID: widths, register indexes, setpoint select codes,
// reset values, divider handshake types and saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spid_pkg;

    localparam int ADC_BITS      = 12;
    localparam int INTEGRAL_BITS = 48;
    localparam int ANGLE_W       = 16;
    localparam int MUL_A_W       = 33;
    localparam int MUL_B_W       = 25;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam int DIV_W         = 38;
    localparam int DIVISOR_W     = 16;
    localparam int DIV_CNT_W     = $clog2(DIV_W);
    localparam int SUM_W         = 48;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_KP    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KD    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAN  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TOL   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PLIM  = 3'd7;

    // setpoint select codes carried in s_tuser
    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_REMOTE = 2'd1;
    localparam logic [1:0] MODE_NAV    = 2'd2;
    localparam logic [1:0] MODE_KEEP   = 2'd3;

    localparam logic [11:0] LEFT_RST  = 12'd2845;
    localparam logic [11:0] RIGHT_RST = 12'd870;
    localparam logic [14:0] SPAN_RST  = 15'd11960;
    localparam logic [14:0] TOL_RST   = 15'd115;
    localparam logic [7:0]  PLIM_RST  = 8'd150;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } spid_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } spid_div_rsp_t;

    // Saturate a signed value to 16 bits signed.
    function automatic logic signed [ANGLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32767);
        lo = -SUM_W'(32768);
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/spid_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on spid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spid_mul
    import spid_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] op_a,
    input  wire logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(op_a) * MUL_P_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/spid_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on spid_pkg (widths, request/response structs).
`timescale 1ns / 1ps
`default_nettype none

module spid_div
    import spid_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire spid_div_req_t req,
    output spid_div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/steering_pid_with_deadband_top.sv =====
// Steering PID with deadband: sequencer, state and registers around the
// shared multiplier (spid_mul) and divider (spid_div). Uses spid_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "steering_pid_with_deadband_top_defines.svh"

// Usage
// - s_* channel: one steering update per transaction (sensor sample, elapsed
//   ms, two setpoints in s_tdata; setpoint select mode in s_tuser).
// - m_* channel: one result per update (drive, direction, effort, angle, error).
// - cfg_*: gain/limit registers; write them only while the block is idle (the block does not enforce this).
// Sequence
// - Two passes through the 38-step divider (angle mapping, derivative
//   term) make up most of an update, plus six passes through the one
//   multiplier. s_tready is low while an update runs and rises as the
//   result is loaded into the output register, so a new update is taken
//   only after the last one finishes. Equal pot limits or zero elapsed
//   time each skip one divide.
// Reset
// - rst_n clears the integrator, previous error, held setpoint/drive/direction
//   and loads the register defaults; no output is pending afterwards.
// Stalls
// - A result waits in the output register while m_tready is low. A new update
//   can be taken meanwhile; it finishes its math and then waits at the last
//   step until the output register is free.
module steering_pid_with_deadband_top
    import spid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] sensor_sample, [27:12] elapsed_ms, [43:28] remote_setpoint,
    // [59:44] nav_setpoint, [63:60] zero
    input  wire logic [63:0]           s_tdata,
    // [1:0] setpoint_sel
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] drive_level, [8] steer_right, [17:9] effort, [33:18] measured_angle,
    // [49:34] angle_error, [55:50] zero
    output logic [55:0]                m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MNUM, ST_DIVA, ST_WDIVA, ST_ERR, ST_MADD, ST_INT, ST_DDIV,
        ST_WDIVD, ST_MP, ST_MIA, ST_MIB, ST_ITERM, ST_EFF
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [19:0] kp_reg, kd_reg;
    logic [23:0] ki_reg;
    logic [11:0] left_reg, right_reg;
    logic [14:0] span_reg, tol_reg;
    logic [7:0]  plim_reg;

    // controller state
    logic signed [INTEGRAL_BITS-1:0] integ_reg, integ_next;
    logic signed [ANGLE_W-1:0]       prev_reg, prev_next;
    logic signed [ANGLE_W-1:0]       setp_reg, setp_next;
    logic [7:0]                      drive_reg, drive_next;
    logic                            dir_reg, dir_next;

    // per-update working registers
    logic [ADC_BITS-1:0]       sample_reg, sample_next;
    logic [15:0]               elapsed_reg, elapsed_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic signed [ANGLE_W-1:0] err_reg, err_next;
    logic                      neg_reg, neg_next;
    logic signed [DIV_W:0]     d_reg, d_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [36:0]               ia_reg, ia_next;
    logic                      iovf_reg, iovf_next;

    // output register
    logic       ovalid_reg, ovalid_next;
    logic [55:0] odata_reg, odata_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    spid_div_req_t             div_req;
    spid_div_rsp_t             div_rsp;

    spid_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    spid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic                            in_acc;
    logic                            out_acc;
    logic signed [12:0]              den;
    logic signed [12:0]              num_base;
    logic [12:0]                     den_mag;
    logic [MUL_P_W-1:0]              prod_mag;
    logic signed [DIV_W+1:0]         angle_wide;
    logic signed [DIV_W:0]           quo_s;
    logic signed [INTEGRAL_BITS:0]   integ_sum;
    logic [INTEGRAL_BITS-1:0]        imag;
    logic signed [16:0]              diff;
    logic [45:0]                     iq;
    logic [45:0]                     ir;
    logic signed [SUM_W-1:0]         ir_s;
    logic [SUM_W-1:0]                sum_mag;
    logic [SUM_W-23:0]               eff_wide;
    logic [7:0]                      eff_mag;
    logic signed [16:0]              err_w;
    logic signed [16:0]              tol_w;
    logic signed [8:0]               eff_s;
    logic                            out_free;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = ovalid_reg && m_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign den      = $signed({1'b0, right_reg}) - $signed({1'b0, left_reg});
    assign den_mag  = den[12] ? 13'(-den) : 13'(den);
    assign num_base = $signed({1'b0, sample_reg}) - $signed({1'b0, left_reg});
    assign prod_mag = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
    assign quo_s    = neg_reg ? -$signed({1'b0, div_rsp.quotient})
                              : $signed({1'b0, div_rsp.quotient});
    assign angle_wide = (DIV_W+2)'(quo_s) - $signed({(DIV_W-13)'(0), span_reg});
    assign integ_sum  = (INTEGRAL_BITS+1)'(integ_reg) + (INTEGRAL_BITS+1)'(prod);
    assign imag       = integ_reg[INTEGRAL_BITS-1] ? INTEGRAL_BITS'(-integ_reg)
                                                   : INTEGRAL_BITS'(integ_reg);
    assign diff       = 17'(err_reg) - 17'(prev_reg);
    assign iq         = {1'b0, ia_reg, 8'b0} + 46'(prod[55:24]);
    assign ir         = (iovf_reg || iq > 46'(64'd1 << 45)) ? 46'(64'd1 << 45) : iq;
    assign ir_s       = integ_reg[INTEGRAL_BITS-1] ? -$signed({2'b0, ir})
                                                   : $signed({2'b0, ir});
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign eff_wide   = sum_mag[SUM_W-1:22];
    assign eff_mag    = (eff_wide > (SUM_W-22)'(plim_reg)) ? plim_reg : eff_wide[7:0];
    assign err_w      = 17'(err_reg);
    assign tol_w      = $signed({2'b0, tol_reg});

    always_comb
    begin
        state_next   = state_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        setp_next    = setp_reg;
        drive_next   = drive_reg;
        dir_next     = dir_reg;
        sample_next  = sample_reg;
        elapsed_next = elapsed_reg;
        angle_next   = angle_reg;
        err_next     = err_reg;
        neg_next     = neg_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        ia_next      = ia_reg;
        iovf_next    = iovf_reg;
        ovalid_next  = out_acc ? 1'b0 : ovalid_reg;
        odata_next   = odata_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        eff_s        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sample_next  = s_tdata[ADC_BITS-1:0];
                    elapsed_next = s_tdata[27:12];
                    case (s_tuser)
                        MODE_ZERO:   setp_next = '0;
                        MODE_REMOTE: setp_next = s_tdata[43:28];
                        MODE_NAV:    setp_next = s_tdata[59:44];
                        default:     setp_next = setp_reg;
                    endcase
                    state_next = ST_MNUM;
                end
            end
            ST_MNUM:
            begin
                // (sample - left) * 2 * span
                mul_a      = MUL_A_W'(num_base);
                mul_b      = $signed({(MUL_B_W-16)'(0), span_reg, 1'b0});
                state_next = ST_DIVA;
            end
            ST_DIVA:
            begin
                if (den == '0)
                begin
                    angle_next = '0;
                    state_next = ST_ERR;
                end
                else
                begin
                    neg_next         = prod[MUL_P_W-1] ^ den[12];
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_mag[DIV_W-1:0];
                    div_req.divisor  = DIVISOR_W'(den_mag);
                    state_next       = ST_WDIVA;
                end
            end
            ST_WDIVA:
            begin
                if (div_rsp.done)
                begin
                    angle_next = sat16(SUM_W'(angle_wide));
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next   = sat16(SUM_W'(setp_reg) - SUM_W'(angle_reg));
                state_next = ST_MADD;
            end
            ST_MADD:
            begin
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = $signed({(MUL_B_W-16)'(0), elapsed_reg});
                state_next = ST_INT;
            end
            ST_INT:
            begin
                // saturating accumulate of error * elapsed
                if (elapsed_reg != '0)
                begin
                    if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1])
                        integ_next = integ_sum[INTEGRAL_BITS]
                                   ? {1'b1, (INTEGRAL_BITS-1)'(0)}
                                   : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
                    else
                        integ_next = integ_sum[INTEGRAL_BITS-1:0];
                end
                mul_a      = MUL_A_W'(diff);
                mul_b      = $signed({(MUL_B_W-20)'(0), kd_reg});
                state_next = ST_DDIV;
            end
            ST_DDIV:
            begin
                if (elapsed_reg == '0)
                begin
                    d_next     = '0;
                    state_next = ST_MP;
                end
                else
                begin
                    neg_next         = prod[MUL_P_W-1];
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_mag[DIV_W-1:0];
                    div_req.divisor  = elapsed_reg;
                    state_next       = ST_WDIVD;
                end
            end
            ST_WDIVD:
            begin
                if (div_rsp.done)
                begin
                    d_next     = quo_s;
                    state_next = ST_MP;
                end
            end
            ST_MP:
            begin
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = $signed({(MUL_B_W-20)'(0), kp_reg});
                state_next = ST_MIA;
            end
            ST_MIA:
            begin
                sum_next   = SUM_W'(prod) + SUM_W'(d_reg);
                mul_a      = $signed({(MUL_A_W-(INTEGRAL_BITS-32))'(0),
                                      imag[INTEGRAL_BITS-1:32]});
                mul_b      = $signed({1'b0, ki_reg});
                state_next = ST_MIB;
            end
            ST_MIB:
            begin
                iovf_next  = |prod[MUL_P_W-1:37];
                ia_next    = prod[36:0];
                mul_a      = $signed({1'b0, imag[31:0]});
                mul_b      = $signed({1'b0, ki_reg});
                state_next = ST_ITERM;
            end
            ST_ITERM:
            begin
                sum_next   = sum_reg + ir_s;
                state_next = ST_EFF;
            end
            ST_EFF:
            begin
                if (out_free)
                begin
                    if (err_w > tol_w)
                    begin
                        dir_next   = 1'b1;
                        drive_next = sum_reg[SUM_W-1] ? 8'd0 : eff_mag;
                        eff_s      = sum_reg[SUM_W-1] ? -$signed({1'b0, eff_mag})
                                                      : $signed({1'b0, eff_mag});
                    end
                    else if (err_w < -tol_w)
                    begin
                        dir_next   = 1'b0;
                        drive_next = eff_mag;
                        eff_s      = sum_reg[SUM_W-1] ? -$signed({1'b0, eff_mag})
                                                      : $signed({1'b0, eff_mag});
                    end
                    prev_next   = err_reg;
                    ovalid_next = 1'b1;
                    odata_next  = {6'b0, err_reg, angle_reg, eff_s, dir_next, drive_next};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            integ_reg  <= '0;
            prev_reg   <= '0;
            setp_reg   <= '0;
            drive_reg  <= '0;
            dir_reg    <= 1'b0;
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            span_reg   <= SPAN_RST;
            tol_reg    <= TOL_RST;
            plim_reg   <= PLIM_RST;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            integ_reg  <= integ_next;
            prev_reg   <= prev_next;
            setp_reg   <= setp_next;
            drive_reg  <= drive_next;
            dir_reg    <= dir_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_KP:    kp_reg    <= cfg_wdata[19:0];
                    REG_KI:    ki_reg    <= cfg_wdata[23:0];
                    REG_KD:    kd_reg    <= cfg_wdata[19:0];
                    REG_LEFT:  left_reg  <= cfg_wdata[11:0];
                    REG_RIGHT: right_reg <= cfg_wdata[11:0];
                    REG_SPAN:  span_reg  <= cfg_wdata[14:0];
                    REG_TOL:   tol_reg   <= cfg_wdata[14:0];
                    REG_PLIM:  plim_reg  <= cfg_wdata[7:0];
                    default:   plim_reg  <= plim_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        elapsed_reg <= elapsed_next;
        angle_reg   <= angle_next;
        err_reg     <= err_next;
        neg_reg     <= neg_next;
        d_reg       <= d_next;
        sum_reg     <= sum_next;
        ia_reg      <= ia_next;
        iovf_reg    <= iovf_next;
        odata_reg   <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    // an accepted update keeps the input side closed for the next cycle
    `SPID_ASSERT(a_busy_after_accept, in_acc |=> !s_tready)
    // a new result only appears out of the final step
    `SPID_ASSERT(a_result_from_eff, (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == ST_EFF))
    // the divider is never restarted while it is still iterating
    `SPID_NEVER(a_div_overlap, div_req.start && div_rsp.busy)

endmodule

`default_nettype wire
